// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by kfr_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define KFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define KFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/kfr_pkg.sv =====
// ----------------------------------------------------------------------------
// kfr_pkg
// Shared types and constants for the keyframe record and playback core.
// ----------------------------------------------------------------------------
package kfr_pkg;

   typedef enum logic [2:0] {
      ACT_START   = 3'd0,
      ACT_CAPTURE = 3'd1,
      ACT_STOP    = 3'd2,
      ACT_SAMPLE  = 3'd3,
      ACT_DISCARD = 3'd4
   } action_type;

   localparam int TIME_W = 32;
   localparam int ANG_W  = 16;
   localparam int OUT_W  = 20;
   localparam int DVD_W  = 53;   // magnitude of offset * delta
   localparam int PROD_W = 54;   // signed product
   localparam int Q_W    = 21;   // quotient bits that matter

   typedef struct packed {
      logic [TIME_W-1:0]        time_ms;
      logic signed [ANG_W-1:0]  pan;
      logic signed [ANG_W-1:0]  tilt;
      logic                     relay;
   } entry_type;

endpackage

// ===== rtl/core/kfr_ram.sv =====
// ----------------------------------------------------------------------------
// kfr_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module kfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/kfr_div.sv =====
// ----------------------------------------------------------------------------
// kfr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kfr_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [kfr_pkg::DVD_W-1:0]    dividend,
   input  logic [kfr_pkg::TIME_W-1:0]   divisor,
   output logic                         done,
   output logic [kfr_pkg::DVD_W-1:0]    quotient,
   output logic [kfr_pkg::TIME_W-1:0]   remainder
);

   localparam int CNT_W = $clog2(kfr_pkg::DVD_W);

   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [kfr_pkg::DVD_W-1:0]    quo_ff, quo_in;
   logic [kfr_pkg::TIME_W-1:0]   rem_ff, rem_in;
   logic [kfr_pkg::TIME_W-1:0]   dvs_ff, dvs_in;
   logic [kfr_pkg::TIME_W:0]     trial;
   logic                         fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[kfr_pkg::DVD_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         // shift in one dividend bit, subtract where it fits
         rem_in = fits ? kfr_pkg::TIME_W'(trial - {1'b0, dvs_ff})
                       : trial[kfr_pkg::TIME_W-1:0];
         quo_in = {quo_ff[kfr_pkg::DVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(kfr_pkg::DVD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/keyframe_record_and_loop_playback_core.sv =====
// ----------------------------------------------------------------------------
// keyframe_record_and_loop_playback_core
// Keyframe recorder with looped linear-interpolation playback.
// ----------------------------------------------------------------------------
// Every command gives one result word, marked by rsp_strobe for one cycle; the
// receiver cannot stall it. Record, capture, stop and discard answer in the
// cycle after start and keep busy low. A sample on an empty store also answers
// in the cycle after start; with one keyframe or a zero loop length it passes
// through S_ONEW and S_ONE while the first keyframe is read. Otherwise a sample
// runs the loop-length modulo in the shared one-bit-a-cycle divider, primes the
// keyframe RAM read in S_FETCH0 and S_PREV, scans the segments, one entry per
// cycle, and for a segment of nonzero span divides once per axis in the same
// divider. No clearing pass is needed after reset.
module keyframe_record_and_loop_playback_core #(
   parameter int MAX_KEYS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [2:0]                          req_action,
   input  logic [31:0]                         req_time_ms,
   input  logic signed [15:0]                  req_pan_decideg,
   input  logic signed [15:0]                  req_tilt_decideg,
   input  logic                                req_relay_in,
   output logic                                rsp_strobe,
   output logic signed [19:0]                  rsp_pan_out,
   output logic signed [19:0]                  rsp_tilt_out,
   output logic                                rsp_relay_out,
   output logic                                rsp_stored,
   output logic [$clog2(MAX_KEYS+1)-1:0]       rsp_points_held,
   output logic                                rsp_is_recording
);

   localparam int AW = $clog2(MAX_KEYS);
   localparam int CW = $clog2(MAX_KEYS+1);
   localparam int EW = $bits(kfr_pkg::entry_type);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_MODGO  = 11'b000_0000_0010,
      S_MODW   = 11'b000_0000_0100,
      S_FETCH0 = 11'b000_0000_1000,
      S_PREV   = 11'b000_0001_0000,
      S_SCAN   = 11'b000_0010_0000,
      S_MUL    = 11'b000_0100_0000,
      S_DGO    = 11'b000_1000_0000,
      S_DW     = 11'b001_0000_0000,
      S_ONEW   = 11'b010_0000_0000,
      S_ONE    = 11'b100_0000_0000
   } state_type;

   state_type                            state_ff, state_in;
   logic [CW-1:0]                        count_ff, count_in;
   logic [31:0]                          loop_ff, loop_in;
   logic                                 rec_ff, rec_in;
   logic [31:0]                          t_ff, t_in;
   logic [AW-1:0]                        addr_ff, addr_in;
   logic [AW-1:0]                        ci_ff, ci_in;
   kfr_pkg::entry_type                   prev_ff, prev_in;
   kfr_pkg::entry_type                   cur_ff, cur_in;
   logic                                 relay_ff, relay_in;
   logic                                 axis_ff, axis_in;
   logic signed [kfr_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic signed [19:0]                   pan_res_ff, pan_res_in;

   logic                                 rsp_strobe_ff, rsp_strobe_in;
   logic signed [19:0]                   rsp_pan_ff, rsp_pan_in;
   logic signed [19:0]                   rsp_tilt_ff, rsp_tilt_in;
   logic                                 rsp_relay_ff, rsp_relay_in;
   logic                                 rsp_stored_ff, rsp_stored_in;
   logic [CW-1:0]                        rsp_held_ff, rsp_held_in;
   logic                                 rsp_rec_ff, rsp_rec_in;

   logic                                 wr_en;
   kfr_pkg::entry_type                   wr_entry;
   kfr_pkg::entry_type                   rd_entry;
   logic [EW-1:0]                        rd_raw;

   logic                                 div_start;
   logic [kfr_pkg::DVD_W-1:0]            div_dvd;
   logic [31:0]                          div_dvs;
   logic                                 div_done;
   logic [kfr_pkg::DVD_W-1:0]            div_quo;
   logic [31:0]                          div_rem;

   logic [AW-1:0]                        last_idx;
   logic                                 hit;
   logic [31:0]                          off;
   logic signed [15:0]                   ang_a, ang_b;
   logic signed [16:0]                   diff;
   logic signed [20:0]                   delta;
   logic [kfr_pkg::PROD_W-1:0]           prod_mag;
   logic [kfr_pkg::Q_W:0]                q_signed;
   logic signed [19:0]                   lerp_res;

   kfr_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_KEYS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_entry),
      .rd_addr (addr_ff),
      .rd_data (rd_raw)
   );

   kfr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign rd_entry = kfr_pkg::entry_type'(rd_raw);
   assign wr_entry = '{time_ms: req_time_ms, pan: req_pan_decideg,
                       tilt: req_tilt_decideg, relay: req_relay_in};

   always_comb begin
      last_idx = AW'(count_ff - 1'b1);
      hit      = (t_ff >= prev_ff.time_ms) && (t_ff <= rd_entry.time_ms);
      off      = t_ff - prev_ff.time_ms;
      ang_a    = axis_ff ? prev_ff.tilt : prev_ff.pan;
      ang_b    = axis_ff ? cur_ff.tilt  : cur_ff.pan;
      diff     = 17'(ang_b) - 17'(ang_a);
      delta    = {diff, 4'b0000};
      prod_mag = prod_ff[kfr_pkg::PROD_W-1] ? kfr_pkg::PROD_W'(-prod_ff)
                                             : kfr_pkg::PROD_W'(prod_ff);
      q_signed = prod_ff[kfr_pkg::PROD_W-1]
                    ? (kfr_pkg::Q_W+1)'(-{1'b0, div_quo[kfr_pkg::Q_W-1:0]})
                    : {1'b0, div_quo[kfr_pkg::Q_W-1:0]};
      lerp_res = 20'({ang_a, 4'b0000} + q_signed[19:0]);

      div_start = (state_ff == S_MODGO) || (state_ff == S_DGO);
      div_dvs   = (state_ff == S_MODGO) ? loop_ff : cur_ff.time_ms - prev_ff.time_ms;
      div_dvd   = (state_ff == S_MODGO) ? kfr_pkg::DVD_W'(t_ff)
                                        : prod_mag[kfr_pkg::DVD_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      loop_in       = loop_ff;
      rec_in        = rec_ff;
      t_in          = t_ff;
      addr_in       = addr_ff;
      ci_in         = ci_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      relay_in      = relay_ff;
      axis_in       = axis_ff;
      prod_in       = prod_ff;
      pan_res_in    = pan_res_ff;
      wr_en         = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_pan_in    = '0;
      rsp_tilt_in   = '0;
      rsp_relay_in  = 1'b0;
      rsp_stored_in = 1'b0;
      rsp_held_in   = rsp_held_ff;
      rsp_rec_in    = rsp_rec_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_strobe_in = 1'b1;
               unique case (req_action)
                  kfr_pkg::ACT_START: begin
                     rec_in   = 1'b1;
                     count_in = '0;
                     loop_in  = '0;
                  end
                  kfr_pkg::ACT_CAPTURE: begin
                     if (rec_ff && (count_ff < CW'(MAX_KEYS))) begin
                        wr_en         = 1'b1;
                        count_in      = count_ff + 1'b1;
                        loop_in       = req_time_ms;
                        rsp_stored_in = 1'b1;
                     end
                  end
                  kfr_pkg::ACT_STOP: begin
                     rec_in = 1'b0;
                  end
                  kfr_pkg::ACT_SAMPLE: begin
                     t_in = req_time_ms;
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else if ((count_ff == CW'(1)) || (loop_ff == '0)) begin
                        rsp_strobe_in = 1'b0;
                        addr_in       = '0;
                        state_in      = S_ONEW;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        state_in      = S_MODGO;
                     end
                  end
                  kfr_pkg::ACT_DISCARD: begin
                     count_in = '0;
                     loop_in  = '0;
                     rec_in   = 1'b0;
                  end
                  default: begin
                  end
               endcase
               rsp_held_in = count_in;
               rsp_rec_in  = rec_in;
            end
         end
         S_ONEW: begin
            state_in = S_ONE;
         end
         S_ONE: begin
            rsp_strobe_in = 1'b1;
            rsp_pan_in    = {rd_entry.pan, 4'b0000};
            rsp_tilt_in   = {rd_entry.tilt, 4'b0000};
            rsp_relay_in  = rd_entry.relay;
            state_in      = S_IDLE;
         end
         S_MODGO: begin
            state_in = S_MODW;
         end
         S_MODW: begin
            if (div_done) begin
               t_in     = div_rem;
               addr_in  = '0;
               state_in = S_FETCH0;
            end
         end
         S_FETCH0: begin
            addr_in  = addr_ff + 1'b1;
            state_in = S_PREV;
         end
         S_PREV: begin
            prev_in  = rd_entry;
            ci_in    = AW'(1);
            addr_in  = addr_ff + 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (hit) begin
               relay_in = (t_ff >= rd_entry.time_ms) ? rd_entry.relay : prev_ff.relay;
               if (rd_entry.time_ms == prev_ff.time_ms) begin
                  rsp_strobe_in = 1'b1;
                  rsp_pan_in    = {prev_ff.pan, 4'b0000};
                  rsp_tilt_in   = {prev_ff.tilt, 4'b0000};
                  rsp_relay_in  = relay_in;
                  state_in      = S_IDLE;
               end else begin
                  cur_in   = rd_entry;
                  axis_in  = 1'b0;
                  state_in = S_MUL;
               end
            end else if (ci_ff == last_idx) begin
               // fell past every segment: hold the last keyframe
               rsp_strobe_in = 1'b1;
               rsp_pan_in    = {rd_entry.pan, 4'b0000};
               rsp_tilt_in   = {rd_entry.tilt, 4'b0000};
               rsp_relay_in  = rd_entry.relay;
               state_in      = S_IDLE;
            end else begin
               prev_in = rd_entry;
               ci_in   = ci_ff + 1'b1;
            end
         end
         S_MUL: begin
            prod_in  = $signed({1'b0, off}) * delta;
            state_in = S_DGO;
         end
         S_DGO: begin
            state_in = S_DW;
         end
         S_DW: begin
            if (div_done) begin
               if (!axis_ff) begin
                  pan_res_in = lerp_res;
                  axis_in    = 1'b1;
                  state_in   = S_MUL;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_pan_in    = pan_res_ff;
                  rsp_tilt_in   = lerp_res;
                  rsp_relay_in  = relay_ff;
                  state_in      = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         loop_ff       <= '0;
         rec_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_held_ff   <= '0;
         rsp_rec_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         loop_ff       <= loop_in;
         rec_ff        <= rec_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_held_ff   <= rsp_held_in;
         rsp_rec_ff    <= rsp_rec_in;
      end
      t_ff          <= t_in;
      addr_ff       <= addr_in;
      ci_ff         <= ci_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      relay_ff      <= relay_in;
      axis_ff       <= axis_in;
      prod_ff       <= prod_in;
      pan_res_ff    <= pan_res_in;
      rsp_pan_ff    <= rsp_pan_in;
      rsp_tilt_ff   <= rsp_tilt_in;
      rsp_relay_ff  <= rsp_relay_in;
      rsp_stored_ff <= rsp_stored_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_pan_out      = rsp_pan_ff;
   assign rsp_tilt_out     = rsp_tilt_ff;
   assign rsp_relay_out    = rsp_relay_ff;
   assign rsp_stored       = rsp_stored_ff;
   assign rsp_points_held  = rsp_held_ff;
   assign rsp_is_recording = rsp_rec_ff;

endmodule

// ===== rtl/core/kfr_checker.sv =====
// ----------------------------------------------------------------------------
// kfr_checker
// Port-level checks on the keyframe record and playback core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kfr_checker #(
   parameter int CW = 11
) (
   input logic          clock,
   input logic          reset,
   input logic          start,
   input logic          busy,
   input logic [2:0]    req_action,
   input logic          rsp_strobe,
   input logic          rsp_stored,
   input logic          rsp_is_recording,
   input logic [CW-1:0] rsp_points_held
);

   logic cmd_now;
   logic smp_now;
   logic held_rec;

   assign cmd_now  = start && !busy && (req_action != kfr_pkg::ACT_SAMPLE);
   assign smp_now  = start && !busy && (req_action == kfr_pkg::ACT_SAMPLE);
   assign held_rec = rsp_is_recording && (rsp_points_held != '0);

   `KFR_ASSERT_NEXT(a_cmd_answers, clock, reset, cmd_now, rsp_strobe, "command gave no word")
   `KFR_ASSERT_NOW(a_stored_strobe, clock, reset, rsp_stored, rsp_strobe, "stored without word")
   `KFR_ASSERT_NOW(a_stored_rec, clock, reset, rsp_stored, held_rec, "stored while not recording")
   `KFR_ASSERT_NEXT(a_smp_quiet, clock, reset, smp_now, !rsp_stored, "sample reported a store")

endmodule

bind keyframe_record_and_loop_playback_core kfr_checker #(
   .CW ($clog2(MAX_KEYS+1))
) u_kfr_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_action       (req_action),
   .rsp_strobe       (rsp_strobe),
   .rsp_stored       (rsp_stored),
   .rsp_is_recording (rsp_is_recording),
   .rsp_points_held  (rsp_points_held)
);
